@@ rtl/core/wmjc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmjc_pkg: shared types and constants
// Widths, the job record passed from front to back, and the back-end states.
// ----------------------------------------------------------------------------
package wmjc_pkg;

	localparam int MAX_JUMP    = 16;
	localparam int IDX_W       = (MAX_JUMP > 1) ? $clog2(MAX_JUMP) : 1;
	localparam int CNT_W       = $clog2(MAX_JUMP + 1);
	localparam int LIM_W       = 5;
	localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam int HEIGHT_W    = 16;
	localparam int COST_W      = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COST_W-1:0] COST_MAX       = '1;
	localparam logic [LIM_W-1:0]  JUMP_LIMIT_RST = LIM_W'(2);

	typedef struct packed {
		logic [HEIGHT_W-1:0] height;
		logic                last;
		logic                zero_cost;
		logic [CNT_W-1:0]    reach;
	} wmjc_job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_COMMIT
	} wmjc_back_state_t;

endpackage

@@ rtl/core/wmjc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmjc_front: item intake and classification
// Holds the jump limit, counts stones in the sequence and works out how many
// candidates the back end must scan for each item.
// ----------------------------------------------------------------------------
module wmjc_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [wmjc_pkg::LIM_W-1:0]    cfg_data,
	input  logic                          push,
	input  logic [wmjc_pkg::HEIGHT_W-1:0] stone_height,
	input  logic                          first_stone,
	input  logic                          last_stone,
	input  logic                          q_full,
	output logic                          q_push,
	output wmjc_pkg::wmjc_job_t           q_job
);
	import wmjc_pkg::*;

	logic [LIM_W-1:0] jump_limit_q;
	logic [CNT_W-1:0] seen_q;
	logic [CMP_W-1:0] lim_ext;
	logic [CMP_W-1:0] seen_ext;
	logic [CMP_W-1:0] clamp;
	logic [CMP_W-1:0] reach;
	logic             restart;

	assign q_push   = push && !q_full;
	assign restart  = first_stone || (seen_q == '0);
	assign lim_ext  = CMP_W'(jump_limit_q);
	assign seen_ext = CMP_W'(seen_q);

	always_comb begin
		clamp = (lim_ext > CMP_W'(MAX_JUMP)) ? CMP_W'(MAX_JUMP) : lim_ext;
		reach = (clamp > seen_ext) ? seen_ext : clamp;
	end

	assign q_job.height    = stone_height;
	assign q_job.last      = last_stone;
	assign q_job.zero_cost = restart;
	assign q_job.reach     = restart ? '0 : CNT_W'(reach);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jump_limit_q <= JUMP_LIMIT_RST;
			seen_q       <= '0;
		end else begin
			if (cfg_valid) begin
				jump_limit_q <= cfg_data;
			end
			if (q_push) begin
				// saturate the count at the window depth
				if (restart) begin
					seen_q <= CNT_W'(1);
				end else if (seen_q != CNT_W'(MAX_JUMP)) begin
					seen_q <= seen_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

@@ rtl/core/wmjc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmjc_queue: job queue between front and back
// A short first-in first-out register queue; either side may stall.
// ----------------------------------------------------------------------------
module wmjc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  wmjc_pkg::wmjc_job_t wr_job,
	input  logic                rd_en,
	output wmjc_pkg::wmjc_job_t rd_job,
	output logic                full,
	output logic                empty
);
	import wmjc_pkg::*;

	wmjc_job_t         slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

@@ rtl/core/wmjc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmjc_back: candidate scan and commit
// Walks back through the history window with one adder and one comparator,
// then shifts the new stone into the history and loads the result register.
// ----------------------------------------------------------------------------
module wmjc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	input  wmjc_pkg::wmjc_job_t           q_job,
	output logic                          q_pop,
	input  logic                          pop,
	output logic                          empty,
	output logic [wmjc_pkg::COST_W-1:0]   reach_cost,
	output logic                          is_answer
);
	import wmjc_pkg::*;

	wmjc_back_state_t    state_q;
	wmjc_back_state_t    state_d;

	logic [HEIGHT_W-1:0] height_hist_q [MAX_JUMP];
	logic [COST_W-1:0]   cost_hist_q   [MAX_JUMP];

	logic [HEIGHT_W-1:0] h_q;
	logic                last_q;
	logic [CNT_W-1:0]    reach_q;
	logic [IDX_W-1:0]    idx_q;
	logic [COST_W-1:0]   best_q;

	logic                out_valid_q;
	logic [COST_W-1:0]   out_cost_q;
	logic                out_last_q;

	logic [HEIGHT_W-1:0] hist_h;
	logic [HEIGHT_W-1:0] diff;
	logic [COST_W:0]     cand_wide;
	logic [COST_W-1:0]   cand;
	logic                scan_done;
	logic                commit;
	logic                out_free;

	assign empty      = !out_valid_q;
	assign reach_cost = out_cost_q;
	assign is_answer  = out_last_q;
	assign out_free   = !out_valid_q || pop;

	// one candidate per cycle: earlier cost plus height distance, saturated
	assign hist_h    = height_hist_q[idx_q];
	assign diff      = (h_q >= hist_h) ? (h_q - hist_h) : (hist_h - h_q);
	assign cand_wide = {1'b0, cost_hist_q[idx_q]} + (COST_W + 1)'(diff);
	assign cand      = cand_wide[COST_W] ? COST_MAX : cand_wide[COST_W-1:0];
	assign scan_done = (CNT_W'(idx_q) + CNT_W'(1)) == reach_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		commit  = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_job.zero_cost || (q_job.reach == '0)) begin
						state_d = BK_COMMIT;
					end else begin
						state_d = BK_SCAN;
					end
				end
			end
			BK_SCAN: begin
				if (scan_done) begin
					state_d = BK_COMMIT;
				end
			end
			BK_COMMIT: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			h_q     <= q_job.height;
			last_q  <= q_job.last;
			reach_q <= q_job.reach;
			idx_q   <= '0;
			best_q  <= q_job.zero_cost ? '0 : COST_MAX;
		end
		if (state_q == BK_SCAN) begin
			idx_q <= idx_q + IDX_W'(1);
			if (cand < best_q) begin
				best_q <= cand;
			end
		end
		if (commit) begin
			// shift the window and record the new stone at the front
			for (int i = MAX_JUMP - 1; i > 0; i--) begin
				height_hist_q[i] <= height_hist_q[i-1];
				cost_hist_q[i]   <= cost_hist_q[i-1];
			end
			height_hist_q[0] <= h_q;
			cost_hist_q[0]   <= best_q;
			out_cost_q       <= best_q;
			out_last_q       <= last_q;
		end
	end

endmodule

@@ rtl/core/windowed_min_jump_cost.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_min_jump_cost: least-cost jump chain over a sliding window
// Each stone's cost is the least earlier cost plus height distance over the
// allowed back distances; every stone yields one cost item.
// ----------------------------------------------------------------------------
//
//  channel   handshake                     payload
//  -------   ---------------------------   ---------------------------------
//  input     push in, full out             stone_height, first_stone,
//                                          last_stone
//  result    empty out, pop in             reach_cost, is_answer
//  config    cfg_valid in, cfg_ready out   cfg_data (jump limit)
//
//  In the back end an item is first taken from the queue; then its reach
//  candidates (at most MAX_JUMP) pass one per cycle through the shared
//  adder and comparator, and last the item is committed. An item with no
//  candidates, or the first of a sequence, goes straight to commit.
//  Reset clears the jump limit to 2, the stone count and all handshake state.
//  The front stalls only when the two-entry job queue is full; the back
//  stalls in commit while the result register holds an item not yet popped.
//
module windowed_min_jump_cost (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [wmjc_pkg::LIM_W-1:0]    cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [wmjc_pkg::HEIGHT_W-1:0] stone_height,
	input  logic                          first_stone,
	input  logic                          last_stone,
	output logic                          empty,
	input  logic                          pop,
	output logic [wmjc_pkg::COST_W-1:0]   reach_cost,
	output logic                          is_answer
);
	import wmjc_pkg::*;

	wmjc_job_t front_job;
	wmjc_job_t back_job;
	logic      front_push;
	logic      back_pop;
	logic      q_full;
	logic      q_empty;

	// the user writes the limit only while idle; not enforced, so always take it
	assign cfg_ready = 1'b1;
	assign full      = q_full;

	// classify the item and count the stones of the sequence
	wmjc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.push         (push),
		.stone_height (stone_height),
		.first_stone  (first_stone),
		.last_stone   (last_stone),
		.q_full       (q_full),
		.q_push       (front_push),
		.q_job        (front_job)
	);

	// decouple intake from the scan
	wmjc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (front_push),
		.wr_job (front_job),
		.rd_en  (back_pop),
		.rd_job (back_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// scan the window, commit the cost, hold it for the consumer
	wmjc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (back_job),
		.q_pop      (back_pop),
		.pop        (pop),
		.empty      (empty),
		.reach_cost (reach_cost),
		.is_answer  (is_answer)
	);

endmodule
